// ----- sv/q2e_pkg.sv -----
// shared types, widths and arctangent steps for the quaternion to euler pipeline
package q2e_pkg;

   localparam int NORM_W = 35;
   localparam int PROD_W = 32;
   localparam int ISQ_W = 61;
   localparam int ISQ_STEPS = 31;
   localparam int ANG_W = 34;
   localparam int RSHIFT_STAGES = 6;
   localparam int LSHIFT_STAGES = 5;
   localparam int NORM_STAGES = RSHIFT_STAGES + LSHIFT_STAGES;
   localparam int ATAN_LEN = 24;
   localparam int PAIRS = 3;
   localparam int PAIR_ROLL = 0;
   localparam int PAIR_PITCH = 1;
   localparam int PAIR_YAW = 2;

   typedef logic signed [ANG_W-1:0] angle_type;

   localparam angle_type ATAN_STEPS [ATAN_LEN] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
      34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
      34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
      34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
      34'sd652, 34'sd326, 34'sd163, 34'sd81
   };

   localparam angle_type QUARTER_TURN = 34'sd1073741824;

   typedef struct packed {
      logic signed [NORM_W-1:0] x;
      logic signed [NORM_W-1:0] y;
   } vec_type;

   typedef struct packed {
      vec_type roll;
      vec_type yaw;
      logic signed [PROD_W-1:0] s;
   } dly_type;

   function automatic logic [NORM_W:0] vmag(input logic signed [NORM_W-1:0] v);
      logic signed [NORM_W:0] e;
      e = (NORM_W+1)'(v);
      return e[NORM_W] ? unsigned'(-e) : unsigned'(e);
   endfunction

endpackage

// ----- sv/q2e_isqrt_cell.sv -----
// one digit step of the pipelined floor square root
module q2e_isqrt_cell import q2e_pkg::*; #(
   parameter int BIT_EXP = 0
) (
   input  logic             clock,
   input  logic [ISQ_W-1:0] rem_i,
   input  logic [ISQ_W-1:0] res_i,
   output logic [ISQ_W-1:0] rem_o,
   output logic [ISQ_W-1:0] res_o
);
   localparam logic [ISQ_W:0] BIT_VAL = (ISQ_W+1)'(1) << BIT_EXP;

   logic [ISQ_W:0]   trial;
   logic [ISQ_W-1:0] rem_in, res_in, rem_ff, res_ff;

   always_comb begin
      trial = {1'b0, res_i} + BIT_VAL;
      if ({1'b0, rem_i} >= trial) begin
         rem_in = ISQ_W'({1'b0, rem_i} - trial);
         res_in = (res_i >> 1) + ISQ_W'(BIT_VAL);
      end else begin
         rem_in = rem_i;
         res_in = res_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign rem_o = rem_ff;
   assign res_o = res_ff;
endmodule

// ----- sv/q2e_norm_cell.sv -----
// one binary search step of the power of two scaling ahead of the cordic
module q2e_norm_cell import q2e_pkg::*; #(
   parameter bit LEFT = 1'b0,
   parameter int SHIFT = 1,
   parameter int HI_LIMIT = 16384,
   parameter int LO_LIMIT = 8192
) (
   input  logic    clock,
   input  vec_type vec_i,
   output vec_type vec_o
);
   logic [NORM_W:0] mag_x, mag_y, mag_m;
   logic            hit;
   vec_type         vec_in, vec_ff;

   always_comb begin
      vec_in = vec_i;
      if (!LEFT) begin
         // would one step less than this still leave the pair too large
         mag_x = vmag(vec_i.x >>> (SHIFT - 1));
         mag_y = vmag(vec_i.y >>> (SHIFT - 1));
         mag_m = (mag_x > mag_y) ? mag_x : mag_y;
         hit = 64'(mag_m) >= 64'(HI_LIMIT);
         if (hit) begin
            vec_in.x = vec_i.x >>> SHIFT;
            vec_in.y = vec_i.y >>> SHIFT;
         end
      end else begin
         mag_x = vmag(vec_i.x);
         mag_y = vmag(vec_i.y);
         mag_m = (mag_x > mag_y) ? mag_x : mag_y;
         hit = (64'(mag_m) << (SHIFT - 1)) < 64'(LO_LIMIT);
         if (hit) begin
            vec_in.x = vec_i.x <<< SHIFT;
            vec_in.y = vec_i.y <<< SHIFT;
         end
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   assign vec_o = vec_ff;
endmodule

// ----- sv/q2e_cordic_cell.sv -----
// one cordic vectoring micro-rotation with its angle accumulator
module q2e_cordic_cell import q2e_pkg::*; #(
   parameter int CW = 18,
   parameter int IDX = 0
) (
   input  logic                 clock,
   input  logic signed [CW-1:0] x_i,
   input  logic signed [CW-1:0] y_i,
   input  angle_type            acc_i,
   input  logic                 zero_i,
   output logic signed [CW-1:0] x_o,
   output logic signed [CW-1:0] y_o,
   output angle_type            acc_o,
   output logic                 zero_o
);
   logic signed [CW-1:0] dx, dy, x_in, y_in, x_ff, y_ff;
   angle_type            acc_in, acc_ff;
   logic                 zero_ff;

   always_comb begin
      dx = y_i >>> IDX;
      dy = x_i >>> IDX;
      if (!y_i[CW-1]) begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         acc_in = acc_i + ATAN_STEPS[IDX];
      end else begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         acc_in = acc_i - ATAN_STEPS[IDX];
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      zero_ff <= zero_i;
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign acc_o = acc_ff;
   assign zero_o = zero_ff;
endmodule

// ----- sv/quaternion_to_euler_angles.sv -----
// throughput: one quaternion per cycle, busy is always low
// path: products, sums, square, 31 square root digits, 11 scaling steps, pre-rotation,
// one cordic cell per stage and a rounding register; the receiver cannot stall
// reset clears only the valid line, so no strobe comes out of a pipeline flushed by reset
module quaternion_to_euler_angles import q2e_pkg::*; #(
   parameter int CORDIC_STAGES = 16,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle,
   output logic               rsp_pitch_clamped
);
   localparam int CW = SAMPLE_WIDTH + 2;
   localparam int HI_LIMIT = 1 << (SAMPLE_WIDTH - 2);
   localparam int LO_LIMIT = 1 << (SAMPLE_WIDTH - 3);
   localparam int LAT = 47 + CORDIC_STAGES;
   localparam int DLY = ISQ_STEPS + 1;
   localparam logic signed [PROD_W-1:0] ONE_Q30 = 32'sd1073741824;
   localparam angle_type HALF_LSB = 34'sd32768;
   localparam angle_type PITCH_MAX = 34'sd16384;

   logic [LAT-1:0] valid_pipe_ff, valid_pipe_in;
   logic [LAT-2:0] clamp_pipe_ff;

   // products, Q2.30
   logic signed [PROD_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff, yz_ff, wx_ff, xy_ff, wz_ff, wy_ff,
      xz_ff;

   // sums
   vec_type                  roll_in, yaw_in, roll_ff, yaw_ff;
   logic signed [NORM_W-1:0] s_raw;
   logic signed [PROD_W-1:0] s_in, s_ff;
   logic                     clamp_in;

   // square root operand
   logic signed [63:0] s_sq;
   logic [ISQ_W-1:0]   n_in, n_ff;

   logic [ISQ_W-1:0] rem_w [ISQ_STEPS+1];
   logic [ISQ_W-1:0] res_w [ISQ_STEPS+1];
   dly_type          dly_ff [DLY];

   vec_type norm_w [PAIRS][NORM_STAGES+1];

   logic signed [CW-1:0] cx_w [PAIRS][CORDIC_STAGES+1];
   logic signed [CW-1:0] cy_w [PAIRS][CORDIC_STAGES+1];
   angle_type            cacc_w [PAIRS][CORDIC_STAGES+1];
   logic                 czero_w [PAIRS][CORDIC_STAGES+1];

   logic signed [CW-1:0] pre_x_in [PAIRS];
   logic signed [CW-1:0] pre_y_in [PAIRS];
   angle_type            pre_acc_in [PAIRS];
   logic                 pre_zero_in [PAIRS];
   logic signed [CW-1:0] pre_x_ff [PAIRS];
   logic signed [CW-1:0] pre_y_ff [PAIRS];
   angle_type            pre_acc_ff [PAIRS];
   logic                 pre_zero_ff [PAIRS];

   angle_type          rnd [PAIRS];
   angle_type          pitch_full;
   logic signed [15:0] roll_out_in, pitch_out_in, yaw_out_in;
   logic signed [15:0] roll_out_ff, pitch_out_ff, yaw_out_ff;

   assign busy = 1'b0;

   // valid line, a transfer enters at every cycle with start high
   always_comb begin
      valid_pipe_in = {valid_pipe_ff[LAT-2:0], start & ~busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pipe_ff <= '0;
      end else begin
         valid_pipe_ff <= valid_pipe_in;
      end
   end

   always_ff @(posedge clock) begin
      ww_ff <= req_quat_w * req_quat_w;
      xx_ff <= req_quat_x * req_quat_x;
      yy_ff <= req_quat_y * req_quat_y;
      zz_ff <= req_quat_z * req_quat_z;
      yz_ff <= req_quat_y * req_quat_z;
      wx_ff <= req_quat_w * req_quat_x;
      xy_ff <= req_quat_x * req_quat_y;
      wz_ff <= req_quat_w * req_quat_z;
      wy_ff <= req_quat_w * req_quat_y;
      xz_ff <= req_quat_x * req_quat_z;
   end

   always_comb begin
      roll_in.y = (NORM_W'(yz_ff) + NORM_W'(wx_ff)) <<< 1;
      roll_in.x = NORM_W'(ww_ff) - NORM_W'(xx_ff) - NORM_W'(yy_ff) + NORM_W'(zz_ff);
      yaw_in.y = (NORM_W'(xy_ff) + NORM_W'(wz_ff)) <<< 1;
      yaw_in.x = NORM_W'(ww_ff) + NORM_W'(xx_ff) - NORM_W'(yy_ff) - NORM_W'(zz_ff);
      s_raw = (NORM_W'(wy_ff) - NORM_W'(xz_ff)) <<< 1;
      clamp_in = 1'b0;
      if (s_raw > NORM_W'(ONE_Q30)) begin
         s_in = ONE_Q30;
         clamp_in = 1'b1;
      end else if (s_raw < -NORM_W'(ONE_Q30)) begin
         s_in = -ONE_Q30;
         clamp_in = 1'b1;
      end else begin
         s_in = PROD_W'(s_raw);
      end
   end

   always_ff @(posedge clock) begin
      roll_ff <= roll_in;
      yaw_ff <= yaw_in;
      s_ff <= s_in;
      clamp_pipe_ff <= {clamp_pipe_ff[LAT-3:0], clamp_in};
   end

   always_comb begin
      s_sq = s_ff * s_ff;
      n_in = ISQ_W'((64'sd1 <<< 60) - s_sq);
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
   end

   // roll, yaw and the sine wait alongside the square root
   always_ff @(posedge clock) begin
      dly_ff[0] <= '{roll: roll_ff, yaw: yaw_ff, s: s_ff};
      for (int i = 1; i < DLY; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end
   end

   assign rem_w[0] = n_ff;
   assign res_w[0] = '0;

   for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isqrt
      q2e_isqrt_cell #(.BIT_EXP(2 * (ISQ_STEPS - 1 - j))) u_cell (
         .clock(clock),
         .rem_i(rem_w[j]),
         .res_i(res_w[j]),
         .rem_o(rem_w[j+1]),
         .res_o(res_w[j+1])
      );
   end

   assign norm_w[PAIR_ROLL][0] = dly_ff[DLY-1].roll;
   assign norm_w[PAIR_YAW][0] = dly_ff[DLY-1].yaw;
   assign norm_w[PAIR_PITCH][0].y = NORM_W'(dly_ff[DLY-1].s);
   assign norm_w[PAIR_PITCH][0].x = NORM_W'({1'b0, res_w[ISQ_STEPS][ISQ_STEPS-1:0]});

   for (genvar p = 0; p < PAIRS; p++) begin : g_pair
      for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
         localparam bit IS_LEFT = (k >= RSHIFT_STAGES);
         localparam int SH = IS_LEFT ? (1 << (NORM_STAGES - 1 - k))
                                     : (1 << (RSHIFT_STAGES - 1 - k));
         q2e_norm_cell #(
            .LEFT(IS_LEFT),
            .SHIFT(SH),
            .HI_LIMIT(HI_LIMIT),
            .LO_LIMIT(LO_LIMIT)
         ) u_cell (
            .clock(clock),
            .vec_i(norm_w[p][k]),
            .vec_o(norm_w[p][k+1])
         );
      end

      // pre-rotation by a quarter turn into the right half plane
      always_comb begin
         pre_zero_in[p] = (norm_w[p][NORM_STAGES].x == '0) && (norm_w[p][NORM_STAGES].y == '0);
         pre_x_in[p] = CW'(norm_w[p][NORM_STAGES].x);
         pre_y_in[p] = CW'(norm_w[p][NORM_STAGES].y);
         pre_acc_in[p] = '0;
         if (norm_w[p][NORM_STAGES].x[NORM_W-1]) begin
            if (!norm_w[p][NORM_STAGES].y[NORM_W-1]) begin
               pre_acc_in[p] = QUARTER_TURN;
               pre_x_in[p] = CW'(norm_w[p][NORM_STAGES].y);
               pre_y_in[p] = -CW'(norm_w[p][NORM_STAGES].x);
            end else begin
               pre_acc_in[p] = -QUARTER_TURN;
               pre_x_in[p] = -CW'(norm_w[p][NORM_STAGES].y);
               pre_y_in[p] = CW'(norm_w[p][NORM_STAGES].x);
            end
         end
      end

      always_ff @(posedge clock) begin
         pre_x_ff[p] <= pre_x_in[p];
         pre_y_ff[p] <= pre_y_in[p];
         pre_acc_ff[p] <= pre_acc_in[p];
         pre_zero_ff[p] <= pre_zero_in[p];
      end

      assign cx_w[p][0] = pre_x_ff[p];
      assign cy_w[p][0] = pre_y_ff[p];
      assign cacc_w[p][0] = pre_acc_ff[p];
      assign czero_w[p][0] = pre_zero_ff[p];

      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
         q2e_cordic_cell #(.CW(CW), .IDX(i)) u_cell (
            .clock(clock),
            .x_i(cx_w[p][i]),
            .y_i(cy_w[p][i]),
            .acc_i(cacc_w[p][i]),
            .zero_i(czero_w[p][i]),
            .x_o(cx_w[p][i+1]),
            .y_o(cy_w[p][i+1]),
            .acc_o(cacc_w[p][i+1]),
            .zero_o(czero_w[p][i+1])
         );
      end

      assign rnd[p] = czero_w[p][CORDIC_STAGES] ? '0 : (cacc_w[p][CORDIC_STAGES] + HALF_LSB);
   end

   // round to 16 bits, roll and yaw wrap, pitch saturates
   always_comb begin
      roll_out_in = rnd[PAIR_ROLL][31:16];
      yaw_out_in = rnd[PAIR_YAW][31:16];
      pitch_full = rnd[PAIR_PITCH] >>> 16;
      if (pitch_full > PITCH_MAX) begin
         pitch_out_in = 16'(PITCH_MAX);
      end else if (pitch_full < -PITCH_MAX) begin
         pitch_out_in = 16'(-PITCH_MAX);
      end else begin
         pitch_out_in = 16'(pitch_full);
      end
   end

   always_ff @(posedge clock) begin
      roll_out_ff <= roll_out_in;
      pitch_out_ff <= pitch_out_in;
      yaw_out_ff <= yaw_out_in;
   end

   assign rsp_valid = valid_pipe_ff[LAT-1];
   assign rsp_roll_angle = roll_out_ff;
   assign rsp_pitch_angle = pitch_out_ff;
   assign rsp_yaw_angle = yaw_out_ff;
   assign rsp_pitch_clamped = clamp_pipe_ff[LAT-2];

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result strobe without a transfer at the pipeline depth");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 16'sd16384) && (rsp_pitch_angle >= -16'sd16384))
      else $error("pitch outside a quarter turn");
`endif
endmodule
